// ===== rtl/core/tvrst_pkg.sv =====
`timescale 1ns / 1ps

package tvrst_pkg;

    // Step kinds
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Register map
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OBJ_ADDR = 3'd3;
    localparam logic [2:0] REG_OBJ_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Timing
    localparam logic [8:0] DOT_LAST      = 9'd340;
    localparam logic [8:0] DOT_SKIP      = 9'd339;
    localparam logic [8:0] LINE_LAST     = 9'd261;
    localparam logic [8:0] LINE_VISIBLE  = 9'd240;
    localparam logic [8:0] LINE_VBLANK   = 9'd241;
    localparam logic [8:0] DOT_VCOPY_LO  = 9'd280;
    localparam logic [8:0] DOT_VCOPY_HI  = 9'd304;
    localparam logic [8:0] DOT_PREF_LO   = 9'd321;
    localparam logic [8:0] DOT_PREF_HI   = 9'd336;
    localparam logic [8:0] DOT_INC_Y     = 9'd256;
    localparam logic [8:0] DOT_HCOPY     = 9'd257;
    localparam logic [3:0] NMI_DELAY     = 4'd15;

    // Address masks
    localparam logic [15:0] VCOPY_KEEP   = 16'h841F;
    localparam logic [15:0] VCOPY_TAKE   = 16'h7BE0;
    localparam logic [15:0] HCOPY_KEEP   = 16'hFBE0;
    localparam logic [15:0] HCOPY_TAKE   = 16'h041F;
    localparam logic [15:0] NT_X_FLIP    = 16'h0400;
    localparam logic [15:0] NT_Y_FLIP    = 16'h0800;
    localparam logic [15:0] FINE_Y_STEP  = 16'h1000;
    localparam logic [15:0] FINE_Y_CLEAR = 16'h8FFF;
    localparam logic [13:0] PALETTE_BASE = 14'h3F00;
    localparam logic [4:0]  ROW_LAST     = 5'd29;
    localparam logic [4:0]  ROW_MAX      = 5'd31;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] vram_data;
        logic [7:0] vram_data_below;
        logic       hit_report;
        logic       overflow_report;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        mem_write;
        logic [15:0] vram_address;
        logic        nmi_pulse;
        logic [8:0]  line;
        logic [8:0]  dot;
    } res_t;

endpackage

// ===== rtl/core/tvrst_channels.sv =====
`timescale 1ns / 1ps

interface tvrst_cmd_if;
    logic               valid;
    logic               ready;
    tvrst_pkg::cmd_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tvrst_res_if;
    logic               valid;
    logic               ready;
    tvrst_pkg::res_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tile_video_register_scroll_timing.sv =====
`timescale 1ns / 1ps

// An accepted beat on cmd is registered into s1, then into the output register that drives res.
// Throughput: one beat per cycle while res takes beats; state updates at the accepting edge and the
// object memory read is registered into the second stage.
// Reset (rst_n, async, active low): dot 340, line 240, all other state zero;
// object memory entries read as zero until written (per-entry valid bits).
module tile_video_register_scroll_timing #(
    parameter int OBJECT_BYTES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    tvrst_cmd_if.sink          cmd,
    tvrst_res_if.source        res
);

    localparam int IDX_W = $clog2(OBJECT_BYTES);

    logic [8:0]  dot_reg, dot_next;
    logic [8:0]  line_reg, line_next;
    logic        odd_reg, odd_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] temp_reg, temp_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  last_reg, last_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic [7:0]  oaddr_reg, oaddr_next;
    logic        vblank_reg, vblank_next;
    logic        nmi_prev_reg, nmi_prev_next;
    logic [3:0]  nmi_delay_reg, nmi_delay_next;
    logic        hit_reg, hit_next;
    logic        ovf_reg, ovf_next;

    tvrst_pkg::res_t s1_reg, s1_next;
    logic            s1_obj_reg, s1_obj_next;
    logic            s1_valid_reg;
    tvrst_pkg::res_t out_reg, out_next;
    logic            out_valid_reg;

    logic             accept;
    logic             s1_advance;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] obj_idx;
    logic [7:0]       mem_rdata;
    logic             rendering;
    logic             on_prerender;
    logic             on_render_row;
    logic             fetch;
    logic             level;

    function automatic logic [IDX_W-1:0] obj_index(input logic [7:0] a);
        logic [8:0] v;
        v = {1'b0, a};
        for (int k = 0; k < 3; k++)
        begin
            if (v >= 9'(OBJECT_BYTES))
            begin
                v = v - 9'(OBJECT_BYTES);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    function automatic logic [15:0] inc_x(input logic [15:0] a);
        logic [15:0] r;
        if (a[4:0] == 5'h1F)
        begin
            r = {a[15:5], 5'd0} ^ tvrst_pkg::NT_X_FLIP;
        end
        else
        begin
            r = a + 16'd1;
        end
        return r;
    endfunction

    function automatic logic [15:0] inc_y(input logic [15:0] a);
        logic [15:0] r;
        logic [4:0]  row;
        if (a[14:12] != 3'd7)
        begin
            r = a + tvrst_pkg::FINE_Y_STEP;
        end
        else
        begin
            r   = a & tvrst_pkg::FINE_Y_CLEAR;
            row = r[9:5];
            if (row == tvrst_pkg::ROW_LAST)
            begin
                row = 5'd0;
                r   = r ^ tvrst_pkg::NT_Y_FLIP;
            end
            else if (row == tvrst_pkg::ROW_MAX)
            begin
                row = 5'd0;
            end
            else
            begin
                row = row + 5'd1;
            end
            r[9:5] = row;
        end
        return r;
    endfunction

    assign s1_advance = !out_valid_reg || res.ready;
    assign cmd.ready  = !s1_valid_reg || s1_advance;
    assign accept     = cmd.valid && cmd.ready;
    assign obj_idx    = obj_index(oaddr_reg);
    assign rendering  = mask_reg[3] || mask_reg[4];

    always_comb
    begin
        dot_next       = dot_reg;
        line_next      = line_reg;
        odd_next       = odd_reg;
        cur_next       = cur_reg;
        temp_next      = temp_reg;
        fine_x_next    = fine_x_reg;
        toggle_next    = toggle_reg;
        ctrl_next      = ctrl_reg;
        mask_next      = mask_reg;
        last_next      = last_reg;
        rbuf_next      = rbuf_reg;
        oaddr_next     = oaddr_reg;
        vblank_next    = vblank_reg;
        nmi_prev_next  = nmi_prev_reg;
        nmi_delay_next = nmi_delay_reg;
        hit_next       = hit_reg;
        ovf_next       = ovf_reg;
        s1_next        = '0;
        s1_obj_next    = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        on_prerender   = 1'b0;
        on_render_row  = 1'b0;
        fetch          = 1'b0;
        level          = 1'b0;

        if (accept)
        begin
            case (cmd.data.mode)
                tvrst_pkg::MODE_TICK:
                begin
                    if (nmi_delay_reg != 4'd0)
                    begin
                        nmi_delay_next = nmi_delay_reg - 4'd1;
                        if (nmi_delay_next == 4'd0 && ctrl_reg[7] && vblank_reg)
                        begin
                            s1_next.nmi_pulse = 1'b1;
                        end
                    end

                    // odd frames drop the last pre-render dot while rendering
                    if (rendering && odd_reg && line_reg == tvrst_pkg::LINE_LAST
                        && dot_reg == tvrst_pkg::DOT_SKIP)
                    begin
                        dot_next  = 9'd0;
                        line_next = 9'd0;
                        odd_next  = !odd_reg;
                    end
                    else if (dot_reg >= tvrst_pkg::DOT_LAST)
                    begin
                        dot_next = 9'd0;
                        if (line_reg >= tvrst_pkg::LINE_LAST)
                        begin
                            line_next = 9'd0;
                            odd_next  = !odd_reg;
                        end
                        else
                        begin
                            line_next = line_reg + 9'd1;
                        end
                    end
                    else
                    begin
                        dot_next = dot_reg + 9'd1;
                    end

                    hit_next = hit_reg || cmd.data.hit_report;
                    ovf_next = ovf_reg || cmd.data.overflow_report;

                    on_prerender  = line_next == tvrst_pkg::LINE_LAST;
                    on_render_row = on_prerender || line_next < tvrst_pkg::LINE_VISIBLE;
                    fetch         = (dot_next >= tvrst_pkg::DOT_PREF_LO
                                     && dot_next <= tvrst_pkg::DOT_PREF_HI)
                                    || (dot_next != 9'd0 && dot_next <= tvrst_pkg::DOT_INC_Y);

                    if (rendering)
                    begin
                        if (on_prerender && dot_next >= tvrst_pkg::DOT_VCOPY_LO
                            && dot_next <= tvrst_pkg::DOT_VCOPY_HI)
                        begin
                            cur_next = (cur_next & tvrst_pkg::VCOPY_KEEP)
                                       | (temp_reg & tvrst_pkg::VCOPY_TAKE);
                        end
                        if (on_render_row)
                        begin
                            if (fetch && dot_next[2:0] == 3'd0)
                            begin
                                cur_next = inc_x(cur_next);
                            end
                            if (dot_next == tvrst_pkg::DOT_INC_Y)
                            begin
                                cur_next = inc_y(cur_next);
                            end
                            if (dot_next == tvrst_pkg::DOT_HCOPY)
                            begin
                                cur_next = (cur_next & tvrst_pkg::HCOPY_KEEP)
                                           | (temp_reg & tvrst_pkg::HCOPY_TAKE);
                            end
                        end
                    end

                    if (line_next == tvrst_pkg::LINE_VBLANK && dot_next == 9'd1)
                    begin
                        vblank_next = 1'b1;
                        level       = ctrl_reg[7];
                        if (level && !nmi_prev_reg)
                        begin
                            nmi_delay_next = tvrst_pkg::NMI_DELAY;
                        end
                        nmi_prev_next = level;
                    end
                    if (on_prerender && dot_next == 9'd1)
                    begin
                        vblank_next   = 1'b0;
                        nmi_prev_next = 1'b0;
                        hit_next      = 1'b0;
                        ovf_next      = 1'b0;
                    end
                end

                tvrst_pkg::MODE_READ:
                begin
                    case (cmd.data.reg_index)
                        tvrst_pkg::REG_STATUS:
                        begin
                            s1_next.read_data = {vblank_reg, hit_reg, ovf_reg, last_reg[4:0]};
                            vblank_next   = 1'b0;
                            nmi_prev_next = 1'b0;
                            toggle_next   = 1'b0;
                        end
                        tvrst_pkg::REG_OBJ_DATA:
                        begin
                            mem_re      = 1'b1;
                            s1_obj_next = 1'b1;
                        end
                        tvrst_pkg::REG_DATA:
                        begin
                            if (cur_reg[13:0] < tvrst_pkg::PALETTE_BASE)
                            begin
                                s1_next.read_data = rbuf_reg;
                                rbuf_next         = cmd.data.vram_data;
                            end
                            else
                            begin
                                s1_next.read_data = cmd.data.vram_data;
                                rbuf_next         = cmd.data.vram_data_below;
                            end
                            cur_next = cur_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
                        end
                        default:
                        begin
                        end
                    endcase
                end

                tvrst_pkg::MODE_WRITE:
                begin
                    last_next = cmd.data.write_data;
                    case (cmd.data.reg_index)
                        tvrst_pkg::REG_CTRL:
                        begin
                            ctrl_next = cmd.data.write_data;
                            level     = cmd.data.write_data[7] && vblank_reg;
                            if (level && !nmi_prev_reg)
                            begin
                                nmi_delay_next = tvrst_pkg::NMI_DELAY;
                            end
                            nmi_prev_next     = level;
                            temp_next[11:10]  = cmd.data.write_data[1:0];
                        end
                        tvrst_pkg::REG_MASK:
                        begin
                            mask_next = cmd.data.write_data;
                        end
                        tvrst_pkg::REG_OBJ_ADDR:
                        begin
                            oaddr_next = cmd.data.write_data;
                        end
                        tvrst_pkg::REG_OBJ_DATA:
                        begin
                            mem_we     = 1'b1;
                            oaddr_next = oaddr_reg + 8'd1;
                        end
                        tvrst_pkg::REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_next[4:0] = cmd.data.write_data[7:3];
                                fine_x_next    = cmd.data.write_data[2:0];
                                toggle_next    = 1'b1;
                            end
                            else
                            begin
                                temp_next[14:12] = cmd.data.write_data[2:0];
                                temp_next[9:5]   = cmd.data.write_data[7:3];
                                toggle_next      = 1'b0;
                            end
                        end
                        tvrst_pkg::REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                temp_next[14]   = 1'b0;
                                temp_next[13:8] = cmd.data.write_data[5:0];
                                toggle_next     = 1'b1;
                            end
                            else
                            begin
                                temp_next[7:0] = cmd.data.write_data;
                                cur_next       = {temp_reg[15:8], cmd.data.write_data};
                                toggle_next    = 1'b0;
                            end
                        end
                        tvrst_pkg::REG_DATA:
                        begin
                            s1_next.mem_write = 1'b1;
                            cur_next = cur_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);
                        end
                        default:
                        begin
                        end
                    endcase
                end

                default:
                begin
                end
            endcase

            s1_next.vram_address = cur_next;
            s1_next.line         = line_next;
            s1_next.dot          = dot_next;
        end
    end

    tvrst_obj_mem #(
        .DEPTH (OBJECT_BYTES),
        .AW    (IDX_W)
    ) u_obj_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (obj_idx),
        .wdata (cmd.data.write_data),
        .re    (mem_re),
        .raddr (obj_idx),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg       <= tvrst_pkg::DOT_LAST;
            line_reg      <= tvrst_pkg::LINE_VISIBLE;
            odd_reg       <= 1'b0;
            cur_reg       <= '0;
            temp_reg      <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            ctrl_reg      <= '0;
            mask_reg      <= '0;
            last_reg      <= '0;
            rbuf_reg      <= '0;
            oaddr_reg     <= '0;
            vblank_reg    <= 1'b0;
            nmi_prev_reg  <= 1'b0;
            nmi_delay_reg <= '0;
            hit_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dot_reg       <= dot_next;
            line_reg      <= line_next;
            odd_reg       <= odd_next;
            cur_reg       <= cur_next;
            temp_reg      <= temp_next;
            fine_x_reg    <= fine_x_next;
            toggle_reg    <= toggle_next;
            ctrl_reg      <= ctrl_next;
            mask_reg      <= mask_next;
            last_reg      <= last_next;
            rbuf_reg      <= rbuf_next;
            oaddr_reg     <= oaddr_next;
            vblank_reg    <= vblank_next;
            nmi_prev_reg  <= nmi_prev_next;
            nmi_delay_reg <= nmi_delay_next;
            hit_reg       <= hit_next;
            ovf_reg       <= ovf_next;
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // memory data joins the result on the way out
    always_comb
    begin
        out_next = s1_reg;
        if (s1_obj_reg)
        begin
            out_next.read_data = mem_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg     <= s1_next;
            s1_obj_reg <= s1_obj_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

endmodule

// ===== rtl/core/tvrst_obj_mem.sv =====
`timescale 1ns / 1ps

module tvrst_obj_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 8'd0;

endmodule
